/* hw/rtl/lbp_3x3_pixel_stream_defines.svh */
// Assertion macros shared by the LBP 3x3 stream RTL.
// Included by lbp3_result_queue.sv and lbp_3x3_pixel_stream.sv; no other dependencies.
`ifndef LBP_3X3_PIXEL_STREAM_DEFINES_SVH
`define LBP_3X3_PIXEL_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
`define LBP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBP_ASSERT(label, clk, rst_n, prop, msg)
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/lbp3_pkg.sv */
// Package for the LBP 3x3 pixel stream: sizes, register indexes, queue entry types.
// No dependencies; used by lbp3_result_queue and lbp_3x3_pixel_stream.
package lbp3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 8;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int FWIDTH_W    = 11;
    localparam int FHEIGHT_W   = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int TDATA_W     = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = CFG_ADDR_W'(1);

    // reset frame size, stored as last index
    localparam logic [COL_W-1:0] RST_COL_LAST = COL_W'(639);
    localparam logic [ROW_W-1:0] RST_ROW_LAST = ROW_W'(479);

    // results caused by one pixel: optional interior one, then optional border one
    typedef struct packed {
        logic              has_int;
        logic              has_bord;
        logic [PIX_W-1:0]  lbp;
        logic [PIX_W-1:0]  pixel;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } pair_t;

    typedef struct packed {
        logic [PIX_W-1:0]  code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              border;
        logic              last;
    } result_t;

endpackage

/* hw/rtl/lbp3_result_queue.sv */
// Result queue for the LBP 3x3 stream: holds per-pixel result pairs and
// serializes them onto the output channel. Depends on lbp3_pkg and the defines header.
`include "lbp_3x3_pixel_stream_defines.svh"

module lbp3_result_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 push,
    input  lbp3_pkg::pair_t                      push_entry,
    output logic [lbp3_pkg::QCNT_W-1:0]          count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lbp3_pkg::result_t                    out_result
);
    import lbp3_pkg::*;

    pair_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                sel_reg, sel_next;
    pair_t               head;
    logic                show_int;
    logic                xfer;
    logic                pop;

    always_comb begin
        head     = mem_reg[rd_ptr_reg];
        show_int = head.has_int && !sel_reg;
        out_valid = (cnt_reg != '0);
        out_result.code   = show_int ? head.lbp : head.pixel;
        out_result.row    = show_int ? head.row - ROW_W'(1) : head.row;
        out_result.col    = show_int ? head.col - COL_W'(1) : head.col;
        out_result.border = !show_int;
        out_result.last   = !(show_int && head.has_bord);
        xfer = out_valid && out_ready;
        pop  = xfer && out_result.last;
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        if (pop) begin
            sel_next = 1'b0;
        end else if (xfer) begin
            sel_next = 1'b1;
        end else begin
            sel_next = sel_reg;
        end
    end

    assign count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
        end
    end

    `LBP_ASSERT(a_no_overflow, aclk, aresetn, push |-> (cnt_reg < QCNT_W'(QUEUE_DEPTH)), "queue overflow")
    `LBP_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
    `LBP_ASSERT(a_entry_nonempty, aclk, aresetn, push |-> (push_entry.has_int || push_entry.has_bord), "empty pair pushed")
    `LBP_ASSERT(a_sel_only_pairs, aclk, aresetn, sel_reg |-> (out_valid && head.has_int && head.has_bord), "bad second-word state")

endmodule

/* hw/rtl/lbp_3x3_pixel_stream.sv */
// 3x3 local binary pattern over a raster pixel stream (top level).
// Depends on lbp3_pkg, lbp3_result_queue and the defines header.
//
// Usage:
//   s_ channel: one 8-bit grayscale pixel per word in s_tdata[7:0], raster order.
//   m_ channel: one result per word. m_tdata = {2'b0, out_column, out_row, code},
//   m_tuser = is_border, m_tlast = last result caused by that input pixel.
//   cfg port: index 0 frame_width, index 1 frame_height; a write to either index
//   restarts the frame at row 0, column 0. Write only while the block is idle.
//   Throughput: one pixel per cycle while m_tready holds high. A pixel causing
//   two results (last column of rows two and up, and the bottom row) holds the
//   output for an extra word; the four-entry result queue absorbs this at row
//   ends, while along the bottom row the input is slowed to the output's pace.
//   Path: a border result is registered with its pixel (v1_reg, px1_reg), then queued;
//   an interior result leaves with the pixel one row down, one column right.
//   The line store is a 1024 x 16 RAM (one read at accept, one write in the following cycle).
//   Reset: frame size 640 x 480, counters and queue cleared, no clearing pass.
//   Receiver stall: results wait in the queue; s_tready drops once the queue
//   cannot take the results of the pixel in flight plus one more.
`include "lbp_3x3_pixel_stream_defines.svh"

module lbp_3x3_pixel_stream (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] pixel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lbp3_pkg::TDATA_W-1:0]         m_tdata,   // code, out_row, out_column, pad
    output logic                                 m_tuser,   // is_border
    output logic                                 m_tlast,   // last
    input  logic                                 cfg_wen,
    input  logic [lbp3_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lbp3_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import lbp3_pkg::*;

    logic [COL_W-1:0]     col_last_reg, col_last_next;
    logic [ROW_W-1:0]     row_last_reg, row_last_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 v1_reg;
    logic [PIX_W-1:0]     px1_reg;
    logic [COL_W-1:0]     c1_reg;
    logic [ROW_W-1:0]     r1_reg;
    logic                 int1_reg, bord1_reg;
    logic [2*PIX_W-1:0]   rd_reg;
    logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]     win_mid_reg [3];
    logic [PIX_W-1:0]     win_right_reg [3];

    logic                 accept;
    logic                 is_int, is_bord;
    logic [FWIDTH_W-1:0]  fw;
    logic [FHEIGHT_W-1:0] fh;
    logic [QCNT_W:0]      need;
    logic [QCNT_W-1:0]    q_count;
    logic [PIX_W-1:0]     above, two_above, center;
    logic [PIX_W-1:0]     lbp;
    pair_t                entry;
    logic                 push;
    logic                 q_valid;
    result_t              res;

    assign need     = {1'b0, q_count} + (QCNT_W+1)'(v1_reg) + (QCNT_W+1)'(1);
    assign s_tready = (need <= (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign is_int   = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    assign is_bord  = (row_reg == '0) || (col_reg == '0)
                   || (row_reg == row_last_reg) || (col_reg == col_last_reg);

    always_comb begin
        fw = cfg_wdata[FWIDTH_W-1:0];
        fh = cfg_wdata[FHEIGHT_W-1:0];
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wen) begin
            case (cfg_addr)
                REG_FRAME_WIDTH: begin
                    if (fw == '0) begin
                        col_last_next = '0;
                    end else if (fw > FWIDTH_W'(MAX_WIDTH)) begin
                        col_last_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        col_last_next = COL_W'(fw - FWIDTH_W'(1));
                    end
                    col_next = '0;
                    row_next = '0;
                end
                REG_FRAME_HEIGHT: begin
                    if (fh == '0) begin
                        row_last_next = '0;
                    end else if (fh > FHEIGHT_W'(MAX_HEIGHT)) begin
                        row_last_next = ROW_W'(MAX_HEIGHT - 1);
                    end else begin
                        row_last_next = ROW_W'(fh - FHEIGHT_W'(1));
                    end
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            if (col_reg == col_last_reg) begin
                col_next = '0;
                row_next = (row_reg == row_last_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg <= RST_COL_LAST;
            row_last_reg <= RST_ROW_LAST;
            col_reg      <= '0;
            row_reg      <= '0;
            v1_reg       <= 1'b0;
        end else begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            v1_reg       <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            px1_reg   <= s_tdata;
            c1_reg    <= col_reg;
            r1_reg    <= row_reg;
            int1_reg  <= is_int;
            bord1_reg <= is_bord;
        end
    end

    // line RAM word: [15:8] row above, [7:0] two rows above
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[col_reg];
        end
        if (v1_reg) begin
            line_mem[c1_reg] <= {px1_reg, rd_reg[2*PIX_W-1:PIX_W]};
        end
    end

    assign above     = rd_reg[2*PIX_W-1:PIX_W];
    assign two_above = rd_reg[PIX_W-1:0];
    assign center    = win_right_reg[1];

    // window after the shift: left = old mid, mid = old right, right = new column
    always_comb begin
        lbp[7] = win_mid_reg[0] > center;
        lbp[6] = win_right_reg[0] > center;
        lbp[5] = two_above > center;
        lbp[4] = above > center;
        lbp[3] = px1_reg > center;
        lbp[2] = win_right_reg[2] > center;
        lbp[1] = win_mid_reg[2] > center;
        lbp[0] = win_mid_reg[1] > center;
        entry.has_int  = int1_reg;
        entry.has_bord = bord1_reg;
        entry.lbp      = lbp;
        entry.pixel    = px1_reg;
        entry.row      = r1_reg;
        entry.col      = c1_reg;
        push = v1_reg && (int1_reg || bord1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win_mid_reg[i]   <= '0;
                win_right_reg[i] <= '0;
            end
        end else if (v1_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_mid_reg[i] <= win_right_reg[i];
            end
            win_right_reg[0] <= two_above;
            win_right_reg[1] <= above;
            win_right_reg[2] <= px1_reg;
        end
    end

    lbp3_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (entry),
        .count      (q_count),
        .out_valid  (q_valid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = {(TDATA_W - PIX_W - ROW_W - COL_W)'(0), res.col, res.row, res.code};
    assign m_tuser  = res.border;
    assign m_tlast  = res.last;

    `LBP_ASSERT(a_border_is_last, aclk, aresetn, (m_tvalid && m_tuser) |-> m_tlast, "border word not last")
    `LBP_ASSERT(a_interior_coords, aclk, aresetn, (m_tvalid && !m_tuser) |-> ((res.row != '0) && (res.col != '0)), "interior word on frame edge")
    `LBP_ASSERT_NEXT(a_pair_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid, "second word of pair missing")

endmodule
